// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files, included by the list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/oal_pkg.sv =====
// Package for the ordered array list: sizes, codes, types and storage helpers.
`default_nettype none
package oal_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int MODE_W   = 2;
   localparam int POS_W    = 11;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_LOCATE = 2'd3
   } mode_type;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // 32-bit field value to stored word: sign-extend, then keep low DATA_WIDTH bits
   function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return w[DATA_WIDTH-1:0];
   endfunction

   // stored word back to the 32-bit field: sign-extend from DATA_WIDTH, then cut
   function automatic logic [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] d);
      logic signed [DATA_WIDTH-1:0] s;
      logic signed [63:0]           w;
      s = d;
      w = 64'(s);
      return w[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ordered_array_list_unit.sv =====
// Ordered array list unit: positional insert, delete, get and locate on a RAM-held list.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_mode, req_position, req_value
//   rsp      out        rsp_valid / rsp_stall  rsp_read_value, rsp_found_position,
//                                              rsp_list_length, rsp_status
//
// With n entries and position p, insert and delete shift entries p..n in the element RAM,
// get reads entry p, locate scans from the front until a hit, one entry per cycle. An append
// or empty-list locate walks nothing; a refusal skips it. Next request after result load.
// Reset: synchronous, clears the fill count and control; no RAM clearing pass.
// Stalls: a finished result waits in the output register under rsp_stall while the
// next request is already taken; only loading the next result waits on it.
`default_nettype none
`include "assert_macros.svh"
module ordered_array_list_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [oal_pkg::MODE_W-1:0]    req_mode,
   input  logic [oal_pkg::POS_W-1:0]     req_position,
   input  logic signed [oal_pkg::VAL_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [oal_pkg::VAL_W-1:0] rsp_read_value,
   output logic [oal_pkg::POS_W-1:0]     rsp_found_position,
   output logic [oal_pkg::POS_W-1:0]     rsp_list_length,
   output logic [oal_pkg::STATUS_W-1:0]  rsp_status
);
   import oal_pkg::*;

   // width for position/count compares without overflow
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // control state
   state_type        state_ff,  state_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] left_ff,   left_in;     // RAM reads still to issue
   logic             dvalid_ff, dvalid_in;   // read data arrives this cycle
   logic             hit_ff,    hit_in;      // locate has matched
   logic             rsp_valid_ff, rsp_valid_in;

   // per-transaction payload
   mode_type              mode_ff,    mode_in;
   logic [ADDR_W-1:0]     pos_idx_ff, pos_idx_in;   // position - 1
   logic [DATA_WIDTH-1:0] value_ff,   value_in;
   logic [ADDR_W-1:0]     ptr_ff,     ptr_in;       // next read address
   logic [ADDR_W-1:0]     daddr_ff,   daddr_in;     // address of arriving data
   logic [VAL_W-1:0]      res_read_ff,   res_read_in;
   logic [CNT_W-1:0]      res_found_ff,  res_found_in;
   status_type            res_status_ff, res_status_in;

   // output register
   logic [VAL_W-1:0]    rsp_read_ff,   rsp_read_in;
   logic [POS_W-1:0]    rsp_found_ff,  rsp_found_in;
   logic [POS_W-1:0]    rsp_length_ff, rsp_length_in;
   status_type          rsp_status_ff, rsp_status_in;

   // RAM port
   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   // request decode
   logic             req_fire;
   logic [CMP_W-1:0] n_ext, p_ext;
   logic             ins_full, ins_bad, rd_bad;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign n_ext    = CMP_W'(count_ff);
   assign p_ext    = CMP_W'(req_position);
   assign ins_full = (count_ff >= CNT_W'(CAPACITY));
   assign ins_bad  = (p_ext == '0) || (p_ext > n_ext + CMP_W'(1));
   assign rd_bad   = (p_ext == '0) || (p_ext > n_ext);

   oal_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      dvalid_in     = 1'b0;
      hit_in        = hit_ff;
      mode_in       = mode_ff;
      pos_idx_in    = pos_idx_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      daddr_in      = ptr_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_read_in   = rsp_read_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in       = mode_type'(req_mode);
               value_in      = to_store(req_value);
               pos_idx_in    = ADDR_W'(p_ext - CMP_W'(1));
               res_read_in   = '0;
               res_found_in  = '0;
               res_status_in = STATUS_OK;
               hit_in        = 1'b0;
               unique case (mode_type'(req_mode))
                  MODE_INSERT: begin
                     if (ins_full) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_FINISH;
                     end else if (ins_bad) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_FINISH;
                     end else begin
                        // shift from the top entry down to the insert point
                        ptr_in   = ADDR_W'(n_ext - CMP_W'(1));
                        left_in  = CNT_W'(n_ext - p_ext + CMP_W'(1));
                        count_in = count_ff + CNT_W'(1);
                        state_in = ST_WALK;
                     end
                  end
                  MODE_DELETE: begin
                     if (rd_bad) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_FINISH;
                     end else begin
                        // first read returns the victim, rest shift down
                        ptr_in   = ADDR_W'(p_ext - CMP_W'(1));
                        left_in  = CNT_W'(n_ext - p_ext + CMP_W'(1));
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_WALK;
                     end
                  end
                  MODE_GET: begin
                     if (rd_bad) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_FINISH;
                     end else begin
                        ptr_in   = ADDR_W'(p_ext - CMP_W'(1));
                        left_in  = CNT_W'(1);
                        state_in = ST_WALK;
                     end
                  end
                  MODE_LOCATE: begin
                     ptr_in   = '0;
                     left_in  = count_ff;
                     state_in = ST_WALK;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end

         ST_WALK: begin
            // issue the next read ahead of the write-back
            if ((left_ff != '0) && !hit_ff) begin
               rd_en     = 1'b1;
               dvalid_in = 1'b1;
               left_in   = left_ff - CNT_W'(1);
               ptr_in    = (mode_ff == MODE_INSERT) ? ptr_ff - ADDR_W'(1)
                                                    : ptr_ff + ADDR_W'(1);
            end

            if (dvalid_ff) begin
               unique case (mode_ff)
                  MODE_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = daddr_ff + ADDR_W'(1);
                  end
                  MODE_DELETE: begin
                     if (daddr_ff == pos_idx_ff) begin
                        res_read_in = from_store(rd_data);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = daddr_ff - ADDR_W'(1);
                     end
                  end
                  MODE_GET: begin
                     res_read_in = from_store(rd_data);
                  end
                  MODE_LOCATE: begin
                     if (!hit_ff && (rd_data == value_ff)) begin
                        hit_in       = 1'b1;
                        res_found_in = CNT_W'(daddr_ff) + CNT_W'(1);
                        left_in      = '0;
                     end
                  end
                  default: ;
               endcase
            end else if (left_ff == '0 || hit_ff) begin
               // walk drained; insert drops the new value into the gap
               if (mode_ff == MODE_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_idx_ff;
                  wr_data = value_ff;
               end
               rd_en     = 1'b0;
               dvalid_in = 1'b0;
               state_in  = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff;
               rsp_found_in  = POS_W'(res_found_ff);
               rsp_length_in = POS_W'(count_ff);
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         dvalid_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         dvalid_ff    <= dvalid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pos_idx_ff    <= pos_idx_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      daddr_ff      <= daddr_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = signed'(rsp_read_ff);
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;
   assign rsp_status         = rsp_status_ff;

   // fill count stays within the store
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   // shift write-back never hits the entry being read in the same cycle
   `ASSERT_NEVER(a_port_clash, clock, reset, rd_en && wr_en && (wr_addr == ptr_ff))
   // read data only ever lands while walking
   `ASSERT_CLK(a_data_in_walk, clock, reset, dvalid_ff |-> (state_ff == ST_WALK))
   // a completed walk hands over to the result stage
   `ASSERT_CLK(a_walk_to_finish, clock, reset,
      (state_ff == ST_WALK && state_in != ST_WALK) |=> (state_ff == ST_FINISH))

endmodule
`default_nettype wire

// ===== hw/rtl/oal_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none
module oal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the ordered array list unit.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import oal_pkg::*;

   localparam int SMALL_ITEMS = 300;  // random transactions on a short list
   localparam int TAIL_ITEMS  = 120;  // random transactions on a longer list
   localparam int LONG_LENGTH = 160;  // length the longer list is grown to
   localparam int MAX_REPORTS = 10;

   // handy corner values; half of them sit on sign and alternating-bit patterns
   localparam logic [VAL_W-1:0] VALUE_POOL [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A
   };

   typedef struct packed {
      logic [VAL_W-1:0]    read_value;
      logic [POS_W-1:0]    found_position;
      logic [POS_W-1:0]    list_length;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   // Shadow copy of the list; works out the result of every accepted transaction
   // and holds those results until the block hands them over.
   class array_list_scoreboard;
      logic [DATA_WIDTH-1:0] entries [CAPACITY];
      int                    length;
      list_result_type       awaited_results [$];
      int unsigned           failures;
      int unsigned           results_seen;
      int unsigned           full_refusals;
      int unsigned           range_refusals;
      int unsigned           locate_hits;
      int                    peak_length;

      // stored word read back as a 32-bit field, sign-extended from the store width
      function logic [VAL_W-1:0] entry_value(int idx);
         logic signed [DATA_WIDTH-1:0] narrow;
         logic signed [63:0]           wide;
         narrow = entries[idx];
         wide = narrow;
         return wide[VAL_W-1:0];
      endfunction

      function void note_request(mode_type mode, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
         list_result_type       want;
         logic signed [63:0]    wide;
         logic [DATA_WIDTH-1:0] word;
         int                    p;
         int                    j;
         want = '0;
         wide = signed'(val);
         word = wide[DATA_WIDTH-1:0];
         p = int'(pos);
         case (mode)
            MODE_INSERT: begin
               // a full list refuses before the position is even looked at
               if (length >= CAPACITY) begin
                  want.status = STATUS_FULL;
                  full_refusals++;
               end else if (p < 1 || p > length + 1) begin
                  want.status = STATUS_RANGE;
                  range_refusals++;
               end else begin
                  for (j = length; j >= p; j--)
                     entries[j] = entries[j-1];
                  entries[p-1] = word;
                  length++;
               end
            end
            MODE_DELETE, MODE_GET: begin
               if (p < 1 || p > length) begin
                  want.status = STATUS_RANGE;
                  range_refusals++;
               end else begin
                  want.read_value = entry_value(p - 1);
                  if (mode == MODE_DELETE) begin
                     for (j = p; j < length; j++)
                        entries[j-1] = entries[j];
                     length--;
                  end
               end
            end
            default: begin
               // locate: first matching entry from the front, position ignored
               for (j = 0; j < length; j++) begin
                  if (entries[j] == word) begin
                     want.found_position = POS_W'(j + 1);
                     locate_hits++;
                     break;
                  end
               end
            end
         endcase
         want.list_length = POS_W'(length);
         if (length > peak_length)
            peak_length = length;
         awaited_results.push_back(want);
      endfunction

      function void check_result(list_result_type got);
         list_result_type want;
         results_seen++;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: result with nothing outstanding: value %0d found %0d len %0d st %0d",
                        $time, $signed(got.read_value), got.found_position,
                        got.list_length, got.status);
            return;
         end
         want = awaited_results.pop_front();
         if (got.read_value !== want.read_value || got.found_position !== want.found_position ||
             got.list_length !== want.list_length || got.status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: mismatch, expected value %0d found %0d len %0d st %0d, ",
                         "got value %0d found %0d len %0d st %0d"}, $time,
                        $signed(want.read_value), want.found_position, want.list_length,
                        want.status, $signed(got.read_value), got.found_position,
                        got.list_length, got.status);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [POS_W-1:0]        rsp_found_position;
   logic [POS_W-1:0]        rsp_list_length;
   logic [STATUS_W-1:0]     rsp_status;

   array_list_scoreboard sb;
   int                   burst_left = 0;
   int unsigned          sent_count = 0;

   ordered_array_list_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop. Some 580 transactions, even with each walking the whole store plus
   // gaps and stalls, come to about 13 ms; this is several times that.
   initial begin
      #60_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Receiver: switches between no stall, scattered stall and long stall runs.
   int stall_regime = 0;
   int regime_left  = 0;
   int run_left     = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (regime_left == 0) begin
            stall_regime = $urandom_range(0, 2);
            regime_left  = $urandom_range(16, 160);
         end else begin
            regime_left--;
         end
         case (stall_regime)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (run_left == 0) begin
                  rsp_stall <= ~rsp_stall;
                  run_left = $urandom_range(1, 12);
               end else begin
                  run_left--;
               end
            end
         endcase
      end
   end

   // Result monitor: a transaction completes at an edge with valid high and stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result('{rsp_read_value, rsp_found_position, rsp_list_length, rsp_status});
   end

   // Present one request and hold it until taken; then maybe end the burst with a gap.
   // Called at a rising edge, so every drive lands as a nonblocking update there.
   task automatic send_request(input mode_type mode, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(mode, pos, val);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   // Sender holds off until every outstanding result has been returned.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
   endtask

   // Corner values, values already in the list (so locate hits), or anything at all.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return VALUE_POOL[$urandom_range(0, 7)];
         1: return (sb.length > 0) ? sb.entry_value($urandom_range(0, sb.length - 1))
                                   : VALUE_POOL[$urandom_range(0, 7)];
         default: return $urandom;
      endcase
   endfunction

   // One random transaction; operation mix steers the length into [lo_len, hi_len].
   // With tail_bias most positions sit near the end, keeping shifts short.
   task automatic random_request(input int lo_len, input int hi_len, input bit tail_bias);
      mode_type         mode;
      logic [POS_W-1:0] pos;
      int               n;
      int               top;
      int               roll;
      int               ins_w;
      int               del_w;
      n = sb.length;
      ins_w = (n < lo_len) ? 65 : ((n >= hi_len) ? 15 : 35);
      del_w = (n > hi_len) ? 50 : ((n < lo_len) ? 10 : 25);
      roll = $urandom_range(0, 99);
      if (roll < ins_w)
         mode = MODE_INSERT;
      else if (roll < ins_w + del_w)
         mode = MODE_DELETE;
      else if (roll < ins_w + del_w + (100 - ins_w - del_w) / 2)
         mode = MODE_GET;
      else
         mode = MODE_LOCATE;
      top = (mode == MODE_INSERT) ? n + 1 : n;
      case ($urandom_range(0, 19))
         0: pos = '0;
         1: pos = POS_W'(top + 1);
         2, 3: pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
         default: begin
            if (mode == MODE_LOCATE)
               pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            else if (top == 0)
               pos = POS_W'(1);
            else if (tail_bias && $urandom_range(0, 3) != 0)
               pos = POS_W'($urandom_range((top > 4) ? top - 3 : 1, top));
            else
               pos = POS_W'($urandom_range(1, top));
         end
      endcase
      send_request(mode, pos, pick_value());
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list refusals, extreme values, front/middle/end inserts,
      // duplicates for locate, out-of-range positions with every position bit set.
      send_request(MODE_GET,    11'd1,     32'h0);
      send_request(MODE_DELETE, 11'd1,     32'h0);
      send_request(MODE_LOCATE, 11'd0,     32'h0);
      send_request(MODE_INSERT, 11'd0,     32'h1);
      send_request(MODE_INSERT, 11'd2,     32'h1);
      send_request(MODE_INSERT, 11'd1,     32'h8000_0000);
      send_request(MODE_INSERT, 11'd2,     32'h7FFF_FFFF);
      send_request(MODE_INSERT, 11'd1,     32'h0);
      send_request(MODE_INSERT, 11'd2,     32'hFFFF_FFFF);
      send_request(MODE_INSERT, 11'd6,     32'h5555_5555);
      send_request(MODE_INSERT, 11'h7FF,   32'hAAAA_AAAA);
      send_request(MODE_GET,    11'd4,     32'h0);
      send_request(MODE_GET,    11'd5,     32'h0);
      send_request(MODE_GET,    11'd0,     32'h0);
      send_request(MODE_LOCATE, 11'h7FF,   32'hFFFF_FFFF);
      send_request(MODE_LOCATE, 11'd3,     32'd12345);
      send_request(MODE_INSERT, 11'd5,     32'hFFFF_FFFF);
      send_request(MODE_LOCATE, 11'd0,     32'hFFFF_FFFF);
      send_request(MODE_DELETE, 11'd1,     32'h0);
      send_request(MODE_DELETE, 11'd4,     32'h0);
      send_request(MODE_DELETE, 11'h7FF,   32'h0);
      send_request(MODE_GET,    11'h400,   32'h0);
      send_request(MODE_LOCATE, 11'd1,     32'h7FFF_FFFF);
      wait_for_results();

      // Random traffic on a short list, where empty and near-empty cases recur.
      repeat (SMALL_ITEMS) random_request(4, 40, 1'b0);
      wait_for_results();

      // Grow a longer list, inserting mostly near the end with random content and the odd read.
      while (sb.length < LONG_LENGTH) begin
         if (sb.length > 0 && $urandom_range(0, 31) == 0)
            send_request(MODE_GET, POS_W'($urandom_range(1, sb.length)), $urandom);
         else
            send_request(MODE_INSERT,
                         POS_W'($urandom_range((sb.length > 2) ? sb.length - 2 : 1,
                                               sb.length + 1)), pick_value());
      end
      wait_for_results();

      // Longer list: bad positions either side, last slot, whole-list walks.
      send_request(MODE_INSERT, 11'd0,                    $urandom);
      send_request(MODE_INSERT, POS_W'(sb.length + 2),    $urandom);
      send_request(MODE_GET,    POS_W'(sb.length),        32'h0);
      send_request(MODE_LOCATE, 11'd0,                    sb.entry_value(sb.length - 1));
      send_request(MODE_LOCATE, 11'd0,                    $urandom);
      send_request(MODE_DELETE, POS_W'(sb.length),        32'h0);
      send_request(MODE_INSERT, POS_W'(sb.length + 1),    32'hAAAA_AAAA);
      send_request(MODE_DELETE, 11'd1,                    32'h0);
      send_request(MODE_INSERT, 11'd1,                    32'h5555_5555);

      // Random traffic just below the longer length.
      repeat (TAIL_ITEMS) random_request(LONG_LENGTH - 6, LONG_LENGTH, 1'b1);
      wait_for_results();

      // quiet spell long enough for any stray result to show
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Sent %0d transactions, checked %0d results, peak list length %0d.",
               sent_count, sb.results_seen, sb.peak_length);
      $display("Refused %0d inserts on a full list and %0d bad positions; %0d locate hits.",
               sb.full_refusals, sb.range_refusals, sb.locate_hits);
      if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d failures, %0d results never returned", sb.failures,
                  sb.awaited_results.size());
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
